// ===== hw/rtl/mcpg_pkg.sv =====
`default_nettype none
package mcpg_pkg;

   localparam int OCTANT_DEPTH = 256;
   localparam int COORD_LIMIT  = 4096;

   localparam int AddrBits   = $clog2(OCTANT_DEPTH);
   localparam int LenBits    = $clog2(OCTANT_DEPTH + 1);
   localparam int CoordBits  = $clog2(COORD_LIMIT);
   localparam int OffsetBits = 8;
   localparam int RadiusBits = 8;
   localparam int EntryBits  = 2 * OffsetBits;
   localparam int PointBits  = 14;
   localparam int SizeBits   = 13;
   localparam int CountBits  = 11;
   localparam int DistBits   = 13;
   localparam int SegBits    = 3;
   localparam int CsrIdxBits = 2;
   localparam int WideBits   = (CoordBits + 2 > SizeBits + 1) ? CoordBits + 2 : SizeBits + 1;

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   localparam logic [CsrIdxBits-1:0] CSR_IMAGE_WIDTH  = CsrIdxBits'(0);
   localparam logic [CsrIdxBits-1:0] CSR_IMAGE_HEIGHT = CsrIdxBits'(1);

   localparam logic [SizeBits-1:0] RESET_WIDTH  = SizeBits'(640);
   localparam logic [SizeBits-1:0] RESET_HEIGHT = SizeBits'(480);

   typedef struct packed {
      logic                 we;
      logic [AddrBits-1:0]  addr;
      logic [EntryBits-1:0] data;
   } wr_type;

   typedef struct packed {
      logic               busy;
      logic [LenBits-1:0] len;
   } fill_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mcpg_channels.sv =====
`default_nettype none
interface mcpg_req_if;
   logic                              valid;
   logic                              ready;
   logic                              opcode;
   logic [mcpg_pkg::CoordBits-1:0]    center_x;
   logic [mcpg_pkg::CoordBits-1:0]    center_y;
   logic [mcpg_pkg::RadiusBits-1:0]   radius;

   modport source (output valid, opcode, center_x, center_y, radius, input ready);
   modport sink (input valid, opcode, center_x, center_y, radius, output ready);
endinterface

interface mcpg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mcpg_pkg::PointBits-1:0] point_x;
   logic signed [mcpg_pkg::PointBits-1:0] point_y;
   logic                                 inside_res;
   logic                                 point_valid;
   logic                                 last_point;
   logic [mcpg_pkg::CountBits-1:0]       point_count;

   modport source (output valid, point_x, point_y, inside_res, point_valid, last_point,
                   point_count, input ready);
   modport sink (input valid, point_x, point_y, inside_res, point_valid, last_point,
                 point_count, output ready);
endinterface

interface mcpg_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mcpg_pkg::CsrIdxBits-1:0]   index;
   logic [mcpg_pkg::SizeBits-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mcpg_octant_fill.sv =====
`default_nettype none
module mcpg_octant_fill (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [mcpg_pkg::RadiusBits-1:0] radius,
   output mcpg_pkg::wr_type                     wr,
   output mcpg_pkg::fill_stat_type              stat
);

   logic [mcpg_pkg::OffsetBits-1:0]      x_ff, x_in;
   logic [mcpg_pkg::OffsetBits-1:0]      y_ff, y_in;
   logic signed [mcpg_pkg::DistBits-1:0] d_ff, d_in;
   logic [mcpg_pkg::LenBits-1:0]         len_ff, len_in;
   logic                                 busy_ff, busy_in;

   logic                                 step_ok;
   logic                                 d_pos;
   logic [mcpg_pkg::OffsetBits-1:0]      x_step;
   logic [mcpg_pkg::OffsetBits-1:0]      y_step;
   logic signed [mcpg_pkg::DistBits-1:0] dx;
   logic signed [mcpg_pkg::DistBits-1:0] d_step;
   logic signed [mcpg_pkg::DistBits-1:0] d_start;

   always_comb begin
      step_ok = (y_ff > x_ff) && (len_ff < mcpg_pkg::LenBits'(mcpg_pkg::OCTANT_DEPTH));
      d_pos   = d_ff > $signed(mcpg_pkg::DistBits'(0));
      x_step  = x_ff + mcpg_pkg::OffsetBits'(1);
      y_step  = d_pos ? (y_ff - mcpg_pkg::OffsetBits'(1)) : y_ff;
      dx      = $signed(mcpg_pkg::DistBits'(x_step)) - $signed(mcpg_pkg::DistBits'(y_step));
      if (d_pos) begin
         d_step = d_ff + (dx <<< 2) + $signed(mcpg_pkg::DistBits'(10));
      end else begin
         d_step = d_ff + ($signed(mcpg_pkg::DistBits'(x_step)) <<< 2)
                  + $signed(mcpg_pkg::DistBits'(6));
      end
      d_start = $signed(mcpg_pkg::DistBits'(3)) - $signed(mcpg_pkg::DistBits'({radius, 1'b0}));

      x_in    = x_ff;
      y_in    = y_ff;
      d_in    = d_ff;
      len_in  = len_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = '0;
         y_in    = radius;
         d_in    = d_start;
         len_in  = mcpg_pkg::LenBits'(1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ok) begin
            x_in   = x_step;
            y_in   = y_step;
            d_in   = d_step;
            len_in = len_ff + mcpg_pkg::LenBits'(1);
         end else begin
            busy_in = 1'b0;
         end
      end

      wr.we   = start || (busy_ff && step_ok);
      wr.addr = start ? '0 : len_ff[mcpg_pkg::AddrBits-1:0];
      wr.data = start ? {mcpg_pkg::OffsetBits'(0), radius} : {x_step, y_step};

      stat.busy = busy_ff;
      stat.len  = len_ff;
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      d_ff <= d_in;
      if (reset) begin
         busy_ff <= 1'b0;
         len_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         len_ff  <= len_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/mcpg_mirror.sv =====
`default_nettype none
module mcpg_mirror (
   input  wire logic [mcpg_pkg::EntryBits-1:0] entry,
   input  wire logic [mcpg_pkg::SegBits-1:0]   seg,
   input  wire logic [mcpg_pkg::CoordBits-1:0] cx,
   input  wire logic [mcpg_pkg::CoordBits-1:0] cy,
   input  wire logic [mcpg_pkg::SizeBits-1:0]  width,
   input  wire logic [mcpg_pkg::SizeBits-1:0]  height,
   output logic signed [mcpg_pkg::PointBits-1:0] px,
   output logic signed [mcpg_pkg::PointBits-1:0] py,
   output logic                                in_bounds
);

   logic [mcpg_pkg::OffsetBits-1:0]      ox, oy;
   logic [mcpg_pkg::OffsetBits-1:0]      ax, ay;
   logic signed [mcpg_pkg::WideBits-1:0] cxw, cyw, axw, ayw;
   logic signed [mcpg_pkg::WideBits-1:0] wx, wy;

   always_comb begin
      ox = entry[mcpg_pkg::EntryBits-1:mcpg_pkg::OffsetBits];
      oy = entry[mcpg_pkg::OffsetBits-1:0];
      if (seg inside {3'd1, 3'd2, 3'd5, 3'd6}) begin
         ax = oy;
         ay = ox;
      end else begin
         ax = ox;
         ay = oy;
      end
      cxw = $signed(mcpg_pkg::WideBits'(cx));
      cyw = $signed(mcpg_pkg::WideBits'(cy));
      axw = $signed(mcpg_pkg::WideBits'(ax));
      ayw = $signed(mcpg_pkg::WideBits'(ay));
      wx  = (seg inside {3'd0, 3'd1, 3'd2, 3'd3}) ? cxw + axw : cxw - axw;
      wy  = (seg inside {3'd0, 3'd1, 3'd6, 3'd7}) ? cyw - ayw : cyw + ayw;
      px  = wx[mcpg_pkg::PointBits-1:0];
      py  = wy[mcpg_pkg::PointBits-1:0];
      in_bounds = (wx >= 0) && (wy >= 0)
                  && (wx < $signed(mcpg_pkg::WideBits'(width)))
                  && (wy < $signed(mcpg_pkg::WideBits'(height)));
   end

endmodule
`default_nettype wire

// ===== hw/rtl/midpoint_circle_point_generator.sv =====
// Midpoint circle point generator.
// Items arrive on req_chan (valid/ready). A start beat (opcode 0) latches the
// center and walks the midpoint recurrence for the first octant, writing one
// offset per cycle into a 256-entry octant memory; it answers on rsp_chan with
// the total point count. Each next beat (opcode 1) reads one octant entry,
// mirrors it into the current octant pass and returns one point with its
// in-bounds flag and last marker. The memory read is registered; the mirror
// and bounds check feed the output register. A next beat with no circle
// pending returns an all-zero result.
// Results sit in an output register; when the receiver stalls, that register
// holds, the block takes one more item and keeps it until the register frees.
// Image size registers are written on csr_chan (always ready); writing them
// only while idle is the user's duty, the block does not enforce it.
// Reset sets width 640, height 480 and leaves no circle pending; the octant
// memory is not cleared.
`default_nettype none
module midpoint_circle_point_generator (
   input wire logic    clock,
   input wire logic    reset,
   mcpg_req_if.sink    req_chan,
   mcpg_rsp_if.source  rsp_chan,
   mcpg_csr_if.sink    csr_chan
);

   typedef enum logic [2:0] {
      IDLE_S, FILL_S, START_OUT_S, POINT_OUT_S, EMPTY_OUT_S
   } state_type;

   state_type                             state_ff, state_in;
   logic [mcpg_pkg::SizeBits-1:0]         width_ff, width_in;
   logic [mcpg_pkg::SizeBits-1:0]         height_ff, height_in;
   logic [mcpg_pkg::CoordBits-1:0]        cx_ff, cx_in;
   logic [mcpg_pkg::CoordBits-1:0]        cy_ff, cy_in;
   logic [mcpg_pkg::SegBits-1:0]          seg_ff, seg_in;
   logic [mcpg_pkg::LenBits-1:0]          idx_ff, idx_in;
   logic                                  pending_ff, pending_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [mcpg_pkg::PointBits-1:0] rsp_x_ff, rsp_x_in;
   logic signed [mcpg_pkg::PointBits-1:0] rsp_y_ff, rsp_y_in;
   logic                                  rsp_inside_ff, rsp_inside_in;
   logic                                  rsp_point_ff, rsp_point_in;
   logic                                  rsp_last_ff, rsp_last_in;
   logic [mcpg_pkg::CountBits-1:0]        rsp_count_ff, rsp_count_in;

   logic [mcpg_pkg::EntryBits-1:0]        octant_store_ff [mcpg_pkg::OCTANT_DEPTH];
   logic [mcpg_pkg::EntryBits-1:0]        rd_data_ff;

   mcpg_pkg::wr_type                      wr;
   mcpg_pkg::fill_stat_type               fill_stat;

   logic                                  req_fire;
   logic                                  csr_fire;
   logic                                  slot_free;
   logic                                  fill_start;
   logic                                  rd_en;
   logic [mcpg_pkg::LenBits-1:0]          len;
   logic [mcpg_pkg::LenBits-1:0]          seg_last_idx;
   logic [mcpg_pkg::LenBits-1:0]          next_first;
   logic                                  at_end;
   logic                                  more;
   logic                                  adv_last;
   logic [mcpg_pkg::CountBits-1:0]        total;
   logic signed [mcpg_pkg::PointBits-1:0] mir_x, mir_y;
   logic                                  mir_inside;

   assign req_chan.ready = (state_ff == IDLE_S);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign fill_start     = req_fire && (req_chan.opcode == mcpg_pkg::OP_START);
   assign rd_en          = req_fire && (req_chan.opcode == mcpg_pkg::OP_NEXT) && pending_ff;

   mcpg_octant_fill u_fill (
      .clock  (clock),
      .reset  (reset),
      .start  (fill_start),
      .radius (req_chan.radius),
      .wr     (wr),
      .stat   (fill_stat)
   );

   mcpg_mirror u_mirror (
      .entry     (rd_data_ff),
      .seg       (seg_ff),
      .cx        (cx_ff),
      .cy        (cy_ff),
      .width     (width_ff),
      .height    (height_ff),
      .px        (mir_x),
      .py        (mir_y),
      .in_bounds (mir_inside)
   );

   always_ff @(posedge clock) begin
      if (wr.we) begin
         octant_store_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= octant_store_ff[idx_ff[mcpg_pkg::AddrBits-1:0]];
      end
   end

   always_comb begin
      len          = fill_stat.len;
      seg_last_idx = seg_ff[0] ? ((seg_ff == 3'd7) ? mcpg_pkg::LenBits'(1) : '0)
                               : len - mcpg_pkg::LenBits'(1);
      at_end       = (idx_ff == seg_last_idx);
      more         = ((seg_ff < 3'd6) && (len >= mcpg_pkg::LenBits'(2)))
                     || ((seg_ff == 3'd6) && (len >= mcpg_pkg::LenBits'(3)));
      next_first   = seg_ff[0] ? mcpg_pkg::LenBits'(1) : len - mcpg_pkg::LenBits'(2);
      adv_last     = at_end && !more;
      total        = (len >= mcpg_pkg::LenBits'(2))
                     ? (mcpg_pkg::CountBits'(len) << 3) - mcpg_pkg::CountBits'(8)
                     : mcpg_pkg::CountBits'(1);

      state_in      = state_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      seg_in        = seg_ff;
      idx_in        = idx_ff;
      pending_in    = pending_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_point_in  = rsp_point_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;

      if (csr_fire) begin
         case (csr_chan.index)
            mcpg_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_chan.data;
            mcpg_pkg::CSR_IMAGE_HEIGHT: height_in = csr_chan.data;
            default: ;
         endcase
      end

      case (state_ff)
         IDLE_S: begin
            if (req_fire) begin
               if (req_chan.opcode == mcpg_pkg::OP_START) begin
                  cx_in      = req_chan.center_x;
                  cy_in      = req_chan.center_y;
                  seg_in     = '0;
                  idx_in     = '0;
                  pending_in = 1'b1;
                  state_in   = FILL_S;
               end else if (pending_ff) begin
                  state_in = POINT_OUT_S;
               end else begin
                  state_in = EMPTY_OUT_S;
               end
            end
         end
         FILL_S: begin
            if (!fill_stat.busy) begin
               state_in = START_OUT_S;
            end
         end
         START_OUT_S: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_inside_in = 1'b0;
               rsp_point_in  = 1'b0;
               rsp_last_in   = 1'b0;
               rsp_count_in  = total;
               state_in      = IDLE_S;
            end
         end
         POINT_OUT_S: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = mir_x;
               rsp_y_in      = mir_y;
               rsp_inside_in = mir_inside;
               rsp_point_in  = 1'b1;
               rsp_last_in   = adv_last;
               rsp_count_in  = '0;
               if (!at_end) begin
                  idx_in = seg_ff[0] ? idx_ff - mcpg_pkg::LenBits'(1)
                                     : idx_ff + mcpg_pkg::LenBits'(1);
               end else if (more) begin
                  seg_in = seg_ff + mcpg_pkg::SegBits'(1);
                  idx_in = next_first;
               end else begin
                  pending_in = 1'b0;
               end
               state_in = IDLE_S;
            end
         end
         EMPTY_OUT_S: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_inside_in = 1'b0;
               rsp_point_in  = 1'b0;
               rsp_last_in   = 1'b0;
               rsp_count_in  = '0;
               state_in      = IDLE_S;
            end
         end
         default: begin
            state_in = IDLE_S;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_point_ff  <= rsp_point_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= IDLE_S;
         width_ff     <= mcpg_pkg::RESET_WIDTH;
         height_ff    <= mcpg_pkg::RESET_HEIGHT;
         cx_ff        <= '0;
         cy_ff        <= '0;
         seg_ff       <= '0;
         idx_ff       <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.point_x     = rsp_x_ff;
   assign rsp_chan.point_y     = rsp_y_ff;
   assign rsp_chan.inside_res  = rsp_inside_ff;
   assign rsp_chan.point_valid = rsp_point_ff;
   assign rsp_chan.last_point  = rsp_last_ff;
   assign rsp_chan.point_count = rsp_count_ff;

   // The octant memory is written only by the fill walk.
   assert property (@(posedge clock) disable iff (reset)
      wr.we |-> (fill_start || state_ff == FILL_S))
      else $error("octant write outside of a fill");

   // A point is only ever mirrored from an entry inside the stored octant.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == POINT_OUT_S) |-> (idx_ff < len))
      else $error("octant index beyond the stored length");

   // Emitting the final point leaves nothing pending.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == POINT_OUT_S && slot_free && adv_last) |=> !pending_ff)
      else $error("circle still pending after its last point");

   // A next beat only reaches the point state with a circle pending.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == POINT_OUT_S) |-> pending_ff)
      else $error("point state without a pending circle");

endmodule
`default_nettype wire
